[rtl/singleton_element_filter_macros.svh]
// assertion macros for the singleton element filter
// used by the top level; expects clk_i and rst_ni in the including scope
`ifndef SINGLETON_ELEMENT_FILTER_MACROS_SVH
`define SINGLETON_ELEMENT_FILTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SEF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sef_pkg.sv]
// shared types for the singleton element filter
// no dependencies
package sef_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         last_item;
    logic                         list_empty;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] unique_value;
    logic                         last_result;
    logic                         none_found;
    logic                         overflowed;
  } result_t;

  // contents of one storage cell
  typedef struct packed {
    logic                         valid;
    logic                         dup;
    logic signed [ValueWidth-1:0] value;
  } cell_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                         load;
    logic                         shift;
    logic                         seen;
    logic signed [ValueWidth-1:0] value;
  } cell_ctl_t;

endpackage

[rtl/sef_cell.sv]
// one storage cell of the filter chain: value, valid and duplicate mark
// depends on sef_pkg
module sef_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sef_pkg::cell_ctl_t ctl_i,
  input  logic              prev_valid_i,
  input  sef_pkg::cell_t    next_i,
  output sef_pkg::cell_t    cell_o,
  output logic              match_o
);

  logic                                  valid_q, valid_d;
  logic                                  dup_q, dup_d;
  logic signed [sef_pkg::ValueWidth-1:0] value_q, value_d;
  logic                                  wr;

  // first free cell takes the loaded value
  assign wr      = ctl_i.load && !valid_q && prev_valid_i;
  assign match_o = valid_q && (value_q == ctl_i.value);

  always_comb begin
    valid_d = valid_q;
    dup_d   = dup_q;
    value_d = value_q;
    if (ctl_i.shift) begin
      valid_d = next_i.valid;
      dup_d   = next_i.dup;
      value_d = next_i.value;
    end else if (wr) begin
      valid_d = 1'b1;
      dup_d   = ctl_i.seen;
      value_d = ctl_i.value;
    end else if (ctl_i.load && match_o) begin
      dup_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dup_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      dup_q   <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o = '{valid: valid_q, dup: dup_q, value: value_q};

endmodule

[rtl/singleton_element_filter.sv]
// top level of the singleton element filter: cell chain and emit sequencer
// depends on sef_pkg, sef_cell and singleton_element_filter_macros.svh
//
// usage
//   an item transfers at a rising edge with start_i high and busy_o low
//   each item carries one value; last_item ends the list after storing it,
//   list_empty ends the list without storing anything
//   loading compares each item's value with all stored cells at once and
//   writes it into the first free cell
//   once a list ends, busy_o rises and the chain shifts toward cell 0 one
//   cell per cycle
//   results come out in arrival order; a unique value is held until the next
//   unique value reaches the head, or the chain drains, and comes out in the
//   next cycle, so the final result comes out in the same cycle busy_o falls
//   each result is on result_o for one cycle with result_valid_o high, and
//   the receiver cannot stall
//   the final result has last_result set; a list with no unique value gives
//   one result with none_found set and unique_value zero
//   values arriving with the chain full are dropped and overflowed is set
//   on every result of that list
//   reset empties the chain and returns the sequencer to idle at once
`include "singleton_element_filter_macros.svh"

module singleton_element_filter #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  sef_pkg::in_item_t item_i,
  output logic              result_valid_o,
  output sef_pkg::result_t  result_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;

  sef_pkg::cell_t                        cells [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]                 match;
  sef_pkg::cell_ctl_t                    ctl;

  logic                                  accept;
  logic                                  full;
  logic                                  overflow_q;
  // one result held back so that the final one can carry last_result
  logic                                  pend_valid_q;
  logic signed [sef_pkg::ValueWidth-1:0] pend_value_q;
  logic                                  result_valid_q;
  sef_pkg::result_t                      result_q;

  assign accept = start_i && (state_q == ST_IDLE);
  // cells fill from index 0 upward, so the far end tells us the chain is full
  assign full   = cells[LIST_DEPTH-1].valid;

  always_comb begin
    ctl.load  = accept && !item_i.list_empty && !full;
    ctl.shift = (state_q == ST_EMIT) && cells[0].valid;
    ctl.seen  = |match;
    ctl.value = item_i.value;
  end

  // chain of cells; during the sweep each cell takes its upper neighbor
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic           prev_valid;
    sef_pkg::cell_t next_cell;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cells[i-1].valid;
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign next_cell = '0;
    end else begin : g_link
      assign next_cell = cells[i+1];
    end

    sef_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_valid_i (prev_valid),
      .next_i       (next_cell),
      .cell_o       (cells[i]),
      .match_o      (match[i])
    );
  end

  // sequencer: state, overflow flag, held-back result and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      overflow_q     <= 1'b0;
      pend_valid_q   <= 1'b0;
      pend_value_q   <= '0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            // dropped item: no compare, no marks, just the flag
            if (!item_i.list_empty && full) begin
              overflow_q <= 1'b1;
            end
            if (item_i.list_empty || item_i.last_item) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (cells[0].valid) begin
            if (!cells[0].dup) begin
              // a newer unique value exists, so the held one is not last
              if (pend_valid_q) begin
                result_valid_q <= 1'b1;
                result_q       <= '{unique_value: pend_value_q, last_result: 1'b0,
                                    none_found: 1'b0, overflowed: overflow_q};
              end
              pend_valid_q <= 1'b1;
              pend_value_q <= cells[0].value;
            end
          end else begin
            // chain drained: flush the held value or report none found
            result_valid_q <= 1'b1;
            if (pend_valid_q) begin
              result_q <= '{unique_value: pend_value_q, last_result: 1'b1,
                            none_found: 1'b0, overflowed: overflow_q};
            end else begin
              result_q <= '{unique_value: '0, last_result: 1'b1,
                            none_found: 1'b1, overflowed: overflow_q};
            end
            pend_valid_q <= 1'b0;
            overflow_q   <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // results only follow a cycle of emitting
  `SEF_ASSERT_IMP(a_result_in_emit, result_valid_o, $past(state_q == ST_EMIT), "result outside emit sweep")
  // a none-found result always closes its list
  `SEF_ASSERT_IMP(a_none_is_last, result_valid_o && result_o.none_found, result_o.last_result && (result_o.unique_value == '0), "none_found result malformed")
  // occupied cells stay packed against the head
  `SEF_ASSERT_IMP(a_cells_packed, cells[LIST_DEPTH-1].valid, cells[0].valid, "cell chain has a gap at the head")
  // a final result appears only once the sequencer is back in idle
  `SEF_ASSERT_IMP(a_last_ends_sweep, result_valid_o && result_o.last_result, !busy_o, "sweep did not end")
  // a transfer that ends the list starts the sweep
  `SEF_ASSERT_NEXT(a_end_starts_sweep, start_i && !busy_o && (item_i.list_empty || item_i.last_item), busy_o, "list end did not start the sweep")

endmodule

[tb/sv/singleton_element_filter_tb.sv]
// self-checking testbench for the singleton element filter
// depends on sef_pkg and singleton_element_filter; a scoreboard class predicts the
// unique values of each list and checks every result strobe against them
module singleton_element_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 64;
  localparam int unsigned TargetItems = 380;
  localparam int unsigned MaxReports = 10;

  // scoreboard: shadow copy of the cell chain plus the queue of pending results
  class unique_scoreboard;
    logic signed [sef_pkg::ValueWidth-1:0] cells[Depth];
    bit                                    dup_mark[Depth];
    int unsigned                           fill;
    bit                                    overflow;
    sef_pkg::result_t                      pending_q[$];
    int unsigned                           fail_count;

    function new();
      fill = 0;
      overflow = 1'b0;
      fail_count = 0;
      foreach (dup_mark[i]) dup_mark[i] = 1'b0;
    endfunction

    // list end: queue every unmarked cell in arrival order, then clear
    function void close_list();
      sef_pkg::result_t r;
      int               n;
      n = 0;
      for (int i = 0; i < fill; i++) begin
        if (!dup_mark[i]) begin
          r.unique_value = cells[i];
          r.last_result  = 1'b0;
          r.none_found   = 1'b0;
          r.overflowed   = overflow;
          pending_q.push_back(r);
          n++;
        end
      end
      if (n == 0) begin
        r.unique_value = '0;
        r.last_result  = 1'b1;
        r.none_found   = 1'b1;
        r.overflowed   = overflow;
        pending_q.push_back(r);
      end else begin
        pending_q[pending_q.size()-1].last_result = 1'b1;
      end
      for (int i = 0; i < Depth; i++) dup_mark[i] = 1'b0;
      fill = 0;
      overflow = 1'b0;
    endfunction

    // one transfer into the block
    function void note_item(sef_pkg::in_item_t it);
      bit seen;
      seen = 1'b0;
      if (it.list_empty) begin
        close_list();
        return;
      end
      if (fill >= Depth) begin
        // full chain: value dropped without touching the marks
        overflow = 1'b1;
      end else begin
        for (int i = 0; i < fill; i++) begin
          if (cells[i] == it.value) begin
            dup_mark[i] = 1'b1;
            seen = 1'b1;
          end
        end
        cells[fill] = it.value;
        dup_mark[fill] = seen;
        fill++;
      end
      if (it.last_item) close_list();
    endfunction

    function void report(string what, sef_pkg::result_t want, sef_pkg::result_t got);
      fail_count++;
      if (fail_count <= MaxReports)
        $display({"[%0t] %s: expected value=%0d last=%0b none=%0b ovf=%0b, ",
                  "got value=%0d last=%0b none=%0b ovf=%0b"},
                 $time, what, want.unique_value, want.last_result, want.none_found,
                 want.overflowed, got.unique_value, got.last_result, got.none_found,
                 got.overflowed);
    endfunction

    // one result strobe from the block
    function void check_result(sef_pkg::result_t got);
      sef_pkg::result_t want;
      if (pending_q.size() == 0) begin
        report("result with nothing pending", '0, got);
        return;
      end
      want = pending_q.pop_front();
      if (got.unique_value !== want.unique_value) report("unique_value mismatch", want, got);
      if (got.last_result !== want.last_result) report("last_result mismatch", want, got);
      if (got.none_found !== want.none_found) report("none_found mismatch", want, got);
      if (got.overflowed !== want.overflowed) report("overflowed mismatch", want, got);
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  sef_pkg::in_item_t item_i;
  logic              result_valid_o;
  sef_pkg::result_t  result_o;

  unique_scoreboard sb = new();

  // sender burst state and transfer count
  int unsigned burst_left;
  int unsigned items_sent;

  singleton_element_filter #(
    .LIST_DEPTH(Depth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // monitor: inputs only move on the falling edge, so at the rising edge both the
  // transfer condition and the result strobe are stable; results of an earlier list
  // are always ahead of anything a transfer in this cycle queues
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start_i && !busy_o) sb.note_item(item_i);
    end
  end

  // hard stop in case the block hangs; far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // value source: extremes now and then so the edge encodings show up often
  function automatic logic signed [sef_pkg::ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // present one item and hold it until the transfer happens; the sender runs in
  // bursts, lowering start_i for a random gap between them
  task automatic send_item(logic signed [sef_pkg::ValueWidth-1:0] value, bit last, bit empty);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i.value <= value;
    item_i.last_item <= last;
    item_i.list_empty <= empty;
    do @(posedge clk_i); while (busy_o);
    burst_left--;
    items_sent++;
  endtask

  // hold the sender off until every queued result has come out
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // one list of len elements drawn from a pool of pool_size values (0: all fresh
  // random); closed either by last_item on the final element or by a separate
  // list_empty item, which carries random junk in value and last_item
  task automatic send_list(int unsigned len, int unsigned pool_size, bit close_by_empty);
    logic signed [sef_pkg::ValueWidth-1:0] pool[$];
    logic signed [sef_pkg::ValueWidth-1:0] v;
    for (int i = 0; i < pool_size; i++) pool.push_back(pick_value());
    for (int i = 0; i < len; i++) begin
      if (pool_size == 0) v = pick_value();
      else v = pool[$urandom_range(0, pool_size - 1)];
      send_item(v, !close_by_empty && (i == len - 1), 1'b0);
    end
    if (close_by_empty || len == 0) send_item($urandom, 1'($urandom_range(0, 1)), 1'b1);
  endtask

  initial begin
    int unsigned len;
    int unsigned pool_size;
    int unsigned sel;
    bit          by_empty;

    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    burst_left = 0;
    items_sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed lists
    // empty list with junk in value
    send_item(32'sh7fff_ffff, 1'b0, 1'b1);
    // both flags on an empty chain: list_empty wins
    send_item(32'sh8000_0000, 1'b1, 1'b1);
    // single element
    send_item(32'sh8000_0000, 1'b1, 1'b0);
    // extremes with one repeated zero
    send_item(32'sh7fff_ffff, 1'b0, 1'b0);
    send_item('0, 1'b0, 1'b0);
    send_item('1, 1'b0, 1'b0);
    send_item(32'sh8000_0000, 1'b0, 1'b0);
    send_item('0, 1'b1, 1'b0);
    // every element repeated: no unique value
    send_item(32'sd5, 1'b0, 1'b0);
    send_item(32'sd5, 1'b0, 1'b0);
    send_item(32'sd5, 1'b1, 1'b0);
    // closed by both flags, value would have matched a stored cell
    send_item(32'sd9, 1'b0, 1'b0);
    send_item(32'sd3, 1'b0, 1'b0);
    send_item(32'sd9, 1'b0, 1'b0);
    send_item(32'sd4, 1'b0, 1'b0);
    send_item(32'sd4, 1'b1, 1'b1);
    // values differing in a single bit are distinct
    send_item(32'sh0000_0001, 1'b0, 1'b0);
    send_item(32'sh8000_0001, 1'b0, 1'b0);
    send_item(32'sh0000_0001, 1'b1, 1'b0);
    drain_results();

    // capacity: 64 distinct values fill the chain, then dropped values that equal
    // stored ones must not mark them; every result carries overflowed
    for (int i = 0; i < Depth; i++) send_item(i * 32'sh0101_0101 - 32'sd7, 1'b0, 1'b0);
    send_item(-32'sd7, 1'b0, 1'b0);
    send_item(32'sh0101_0101 - 32'sd7, 1'b1, 1'b0);
    // chain filled exactly, no overflow
    send_list(Depth, 0, 1'b0);
    drain_results();

    // random lists: mostly short with heavy reuse of values, some empty lists,
    // some closed by a list_empty item, and now and then one near or past capacity
    while (items_sent < TargetItems) begin
      sel = $urandom_range(0, 19);
      by_empty = ($urandom_range(0, 5) == 0);
      if (sel == 0) begin
        len = $urandom_range(Depth - 4, Depth + 6);
        pool_size = $urandom_range(0, 1) ? 0 : $urandom_range(Depth / 2, Depth);
      end else if (sel == 1) begin
        len = 0;
        pool_size = 0;
      end else begin
        len = $urandom_range(1, 12);
        pool_size = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, len);
      end
      send_list(len, pool_size, by_empty);
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    drain_results();
    // sweep of a full chain plus margin, in case stray strobes follow
    repeat (Depth + 8) @(posedge clk_i);

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
